@@ design/riff_wave_pcm_stream_decoder_top_defines.svh @@
// Assertion macros shared by the decoder modules
`ifndef RIFF_WAVE_PCM_STREAM_DECODER_TOP_DEFINES_SVH
`define RIFF_WAVE_PCM_STREAM_DECODER_TOP_DEFINES_SVH
// implication check, reset held off
`define RWD_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("check failed");
// next-cycle implication check
`define RWD_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("check failed");
`endif

@@ design/rwd_pkg.sv @@
// ----------------------------------------------------------------------------
// rwd_pkg
// Shared types and constants of the WAVE stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package rwd_pkg;
  localparam int unsigned MAX_FILE_BYTES_D    = 67108864;
  localparam int unsigned MAX_DECODED_BYTES_D = 134217728;
  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [26:0] POS_SAT  = 27'h7FFFFFF;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0, PH_CHUNK = 3'd1, PH_FMT = 3'd2, PH_DATA = 3'd3,
    PH_SKIP = 3'd4, PH_PAD = 3'd5, PH_HALT = 3'd6
  } phase_t;

  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_BADHDR  = 4'd1;
  localparam logic [3:0] ST_PASTEND = 4'd2;
  localparam logic [3:0] ST_SHORT   = 4'd3;
  localparam logic [3:0] ST_MISSING = 4'd4;
  localparam logic [3:0] ST_UNSUP   = 4'd5;
  localparam logic [3:0] ST_MISAL   = 4'd6;
  localparam logic [3:0] ST_EMPTY   = 4'd7;
  localparam logic [3:0] ST_ORDER   = 4'd8;
  localparam logic [3:0] ST_BIG     = 4'd9;

  // word passed from the parser to the emitter queue
  typedef struct packed {
    logic        has_smp;
    logic [15:0] smp;
    logic        slot;
    logic        has_st;
    logic [3:0]  st;
    logic [31:0] rate;
    logic [1:0]  chans;
  } cmd_t;
endpackage
`default_nettype wire

@@ design/rwd_front.sv @@
// ----------------------------------------------------------------------------
// rwd_front
// Byte parser: walks the RIFF chunks and forms one command word per byte.
// ----------------------------------------------------------------------------
`default_nettype none
module rwd_front #(
  parameter int unsigned MAX_FILE_BYTES    = rwd_pkg::MAX_FILE_BYTES_D,
  parameter int unsigned MAX_DECODED_BYTES = rwd_pkg::MAX_DECODED_BYTES_D
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_take,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  output rwd_pkg::cmd_t      cmd,
  output logic               cmd_useful
);
  localparam logic [26:0] CAP1 = 27'(MAX_DECODED_BYTES / 2);
  localparam logic [26:0] CAP2 = 27'(((MAX_DECODED_BYTES / 2) / 2) * 2);
  localparam logic [26:0] LIM1 = 27'(MAX_DECODED_BYTES / 2);
  localparam logic [26:0] LIM2 = 27'((MAX_DECODED_BYTES / 2) / 2);
  localparam logic [26:0] FMAX = 27'(MAX_FILE_BYTES);

  rwd_pkg::phase_t ph_r, ph_nxt;
  logic [26:0] pos_r, pos_nxt;
  logic [31:0] tag_r, tag_nxt, len_r, len_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [15:0] fcode_r, fcode_nxt, fch_r, fch_nxt, fbits_r, fbits_nxt;
  logic [31:0] frate_r, frate_nxt;
  logic        fseen_r, fseen_nxt, dseen_r, dseen_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [26:0] scnt_r, scnt_nxt;
  logic [3:0]  err_r, err_nxt, verd_r, verd_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;

  // supported format and per-chunk checks (cheap, no dividers)
  logic        sup, mono, is8;
  logic [31:0] off;
  logic [26:0] cap, lim, frames;
  logic        misal;
  assign mono = (fch_r == 16'd1);
  assign is8  = (fbits_r == 16'd8);
  assign sup  = (fcode_r == 16'd1) && (mono || fch_r == 16'd2) && (frate_r != 32'd0)
                && (is8 || fbits_r == 16'd16);
  assign off  = len_r - rem_r[31:0];
  assign cap  = mono ? CAP1 : CAP2;
  assign lim  = mono ? LIM1 : LIM2;
  // bytes per frame is 1, 2 or 4: division is a shift
  always_comb begin
    case ({mono, is8})
      2'b11:   begin misal = 1'b0;            frames = len_r[26:0]; end
      2'b10,
      2'b01:   begin misal = len_r[0];        frames = len_r[27:1]; end
      default: begin misal = |len_r[1:0];     frames = len_r[28:2]; end
    endcase
  end
  logic big_len;
  assign big_len = mono ? (is8 ? |len_r[31:27] : |len_r[31:28])
                        : (is8 ? |len_r[31:28] : |len_r[31:29]);

  // next state of the parser
  always_comb begin
    logic [31:0] tagn, clen;
    logic        emit;
    logic [15:0] val;
    tagn = {tag_r[23:0], in_byte};
    clen = len_r;
    emit = 1'b0; val = '0;
    ph_nxt = ph_r; pos_nxt = (pos_r < rwd_pkg::POS_SAT) ? pos_r + 27'd1 : pos_r;
    tag_nxt = tag_r; len_nxt = len_r; rem_nxt = rem_r;
    fcode_nxt = fcode_r; fch_nxt = fch_r; frate_nxt = frate_r; fbits_nxt = fbits_r;
    fseen_nxt = fseen_r; dseen_nxt = dseen_r; low_nxt = low_r; scnt_nxt = scnt_r;
    err_nxt = err_r; verd_nxt = verd_r; hcnt_nxt = hcnt_r;
    case (ph_r)
      rwd_pkg::PH_HEADER: begin
        tag_nxt = tagn;
        if (pos_r == 27'd3 && tagn != rwd_pkg::TAG_RIFF) begin
          err_nxt = rwd_pkg::ST_BADHDR; ph_nxt = rwd_pkg::PH_HALT;
        end else if (pos_r == 27'd11) begin
          if (tagn != rwd_pkg::TAG_WAVE) begin
            err_nxt = rwd_pkg::ST_BADHDR; ph_nxt = rwd_pkg::PH_HALT;
          end else begin
            ph_nxt = rwd_pkg::PH_CHUNK; hcnt_nxt = '0;
          end
        end
      end
      rwd_pkg::PH_CHUNK: begin
        if (hcnt_r < 4'd4) tag_nxt = tagn;
        else begin
          case (hcnt_r[1:0])
            2'd0:    clen = {24'd0, in_byte};
            2'd1:    clen = {len_r[31:16], in_byte, len_r[7:0]};
            2'd2:    clen = {len_r[31:24], in_byte, len_r[15:0]};
            default: clen = {in_byte, len_r[23:0]};
          endcase
          len_nxt = clen;
        end
        hcnt_nxt = hcnt_r + 4'd1;
        if (hcnt_r == 4'd7) begin
          rem_nxt = {1'b0, clen};
          if (tag_r == rwd_pkg::TAG_FMT) begin
            if (dseen_r) begin err_nxt = rwd_pkg::ST_ORDER; ph_nxt = rwd_pkg::PH_HALT; end
            else ph_nxt = rwd_pkg::PH_FMT;
          end else if (tag_r == rwd_pkg::TAG_DATA) begin
            if (!fseen_r) begin err_nxt = rwd_pkg::ST_ORDER; ph_nxt = rwd_pkg::PH_HALT; end
            else if (dseen_r || clen == 32'd0) ph_nxt = rwd_pkg::PH_SKIP;
            else begin dseen_nxt = 1'b1; scnt_nxt = '0; ph_nxt = rwd_pkg::PH_DATA; end
          end else ph_nxt = rwd_pkg::PH_SKIP;
          // zero-length chunk finishes at once (only skip or fmt possible)
          if (clen == 32'd0 && ph_nxt != rwd_pkg::PH_HALT) begin
            if (ph_nxt == rwd_pkg::PH_FMT) begin
              err_nxt = rwd_pkg::ST_SHORT; ph_nxt = rwd_pkg::PH_HALT;
            end else begin
              ph_nxt = rwd_pkg::PH_CHUNK; hcnt_nxt = '0;
            end
          end
        end
      end
      rwd_pkg::PH_FMT, rwd_pkg::PH_DATA, rwd_pkg::PH_SKIP: begin
        if (ph_r == rwd_pkg::PH_FMT && len_r >= 32'd16) begin
          if (off < 32'd2) begin
            if (off[0]) fcode_nxt[15:8] = in_byte; else fcode_nxt[7:0] = in_byte;
          end else if (off < 32'd4) begin
            if (off[0]) fch_nxt[15:8] = in_byte; else fch_nxt[7:0] = in_byte;
          end else if (off < 32'd8) begin
            case (off[1:0])
              2'd0:    frate_nxt[7:0]   = in_byte;
              2'd1:    frate_nxt[15:8]  = in_byte;
              2'd2:    frate_nxt[23:16] = in_byte;
              default: frate_nxt[31:24] = in_byte;
            endcase
          end else if (off == 32'd14) fbits_nxt[7:0] = in_byte;
          else if (off == 32'd15) fbits_nxt[15:8] = in_byte;
        end
        if (ph_r == rwd_pkg::PH_DATA && sup) begin
          if (is8) begin emit = 1'b1; val = {in_byte ^ 8'h80, 8'h00}; end
          else if (!off[0]) low_nxt = in_byte;
          else begin emit = 1'b1; val = {in_byte, low_r}; end
          if (emit && scnt_r >= cap) emit = 1'b0;
          if (emit) scnt_nxt = scnt_r + 27'd1;
        end
        rem_nxt = rem_r - 33'd1;
        if (rem_r == 33'd1) begin
          ph_nxt = len_r[0] ? rwd_pkg::PH_PAD : rwd_pkg::PH_CHUNK;
          hcnt_nxt = '0;
          if (ph_r == rwd_pkg::PH_FMT) begin
            if (len_r < 32'd16) begin err_nxt = rwd_pkg::ST_SHORT; ph_nxt = rwd_pkg::PH_HALT; end
            else fseen_nxt = 1'b1;
          end else if (ph_r == rwd_pkg::PH_DATA && sup) begin
            if (misal) verd_nxt = rwd_pkg::ST_MISAL;
            else if (frames == 27'd0 || big_len || frames > lim) verd_nxt = rwd_pkg::ST_EMPTY;
            else verd_nxt = rwd_pkg::ST_OK;
          end
        end
      end
      rwd_pkg::PH_PAD: begin ph_nxt = rwd_pkg::PH_CHUNK; hcnt_nxt = '0; end
      default: ;
    endcase

    // command word for this byte; status uses state before this byte's reset
    cmd.has_smp = emit;
    cmd.smp     = val;
    cmd.slot    = (fch_r == 16'd2) ? scnt_r[0] : 1'b0;
    cmd.rate    = frate_nxt;
    cmd.chans   = (fch_nxt == 16'd1 || fch_nxt == 16'd2) ? fch_nxt[1:0] : 2'd0;
    cmd.has_st  = in_last;
    begin
      logic sup_n;
      sup_n = (fcode_nxt == 16'd1) && (fch_nxt == 16'd1 || fch_nxt == 16'd2)
              && (frate_nxt != 32'd0) && (fbits_nxt == 16'd8 || fbits_nxt == 16'd16);
      if (err_nxt == rwd_pkg::ST_BADHDR || ph_nxt == rwd_pkg::PH_HEADER)
        cmd.st = rwd_pkg::ST_BADHDR;
      else if (pos_nxt > FMAX) cmd.st = rwd_pkg::ST_BIG;
      else if (err_nxt != rwd_pkg::ST_OK) cmd.st = err_nxt;
      else if ((ph_nxt == rwd_pkg::PH_FMT || ph_nxt == rwd_pkg::PH_DATA ||
                ph_nxt == rwd_pkg::PH_SKIP) && rem_nxt != 33'd0)
        cmd.st = rwd_pkg::ST_PASTEND;
      else if (!fseen_nxt || !dseen_nxt) cmd.st = rwd_pkg::ST_MISSING;
      else if (!sup_n) cmd.st = rwd_pkg::ST_UNSUP;
      else cmd.st = verd_nxt;
    end
    cmd_useful = emit || in_last;
    if (in_last) begin
      ph_nxt = rwd_pkg::PH_HEADER; pos_nxt = '0; tag_nxt = '0; len_nxt = '0;
      rem_nxt = '0; fcode_nxt = '0; fch_nxt = '0; frate_nxt = '0; fbits_nxt = '0;
      fseen_nxt = 1'b0; dseen_nxt = 1'b0; low_nxt = '0; scnt_nxt = '0;
      err_nxt = '0; verd_nxt = '0; hcnt_nxt = '0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= rwd_pkg::PH_HEADER; pos_r <= '0; tag_r <= '0; len_r <= '0; rem_r <= '0;
      fcode_r <= '0; fch_r <= '0; frate_r <= '0; fbits_r <= '0; fseen_r <= 1'b0;
      dseen_r <= 1'b0; low_r <= '0; scnt_r <= '0; err_r <= '0; verd_r <= '0;
      hcnt_r <= '0;
    end else if (in_take) begin
      ph_r <= ph_nxt; pos_r <= pos_nxt; tag_r <= tag_nxt; len_r <= len_nxt;
      rem_r <= rem_nxt; fcode_r <= fcode_nxt; fch_r <= fch_nxt; frate_r <= frate_nxt;
      fbits_r <= fbits_nxt; fseen_r <= fseen_nxt; dseen_r <= dseen_nxt; low_r <= low_nxt;
      scnt_r <= scnt_nxt; err_r <= err_nxt; verd_r <= verd_nxt; hcnt_r <= hcnt_nxt;
    end
  end

  `include "riff_wave_pcm_stream_decoder_top_defines.svh"
  `RWD_ASSERT_IMP(a_hcnt, clk, rst_n, ph_r == rwd_pkg::PH_CHUNK, hcnt_r < 4'd8)
  `RWD_ASSERT_NXT(a_last_rst, clk, rst_n, in_take && in_last, ph_r == rwd_pkg::PH_HEADER)
  `RWD_ASSERT_IMP(a_scnt, clk, rst_n, ph_r == rwd_pkg::PH_DATA, scnt_r <= cap)
  `RWD_ASSERT_IMP(a_hdr, clk, rst_n, ph_r == rwd_pkg::PH_HEADER, pos_r < 27'd12)
endmodule
`default_nettype wire

@@ design/rwd_back.sv @@
// ----------------------------------------------------------------------------
// rwd_back
// Command queue and result sequencer: each word gives a sample, a status or both.
// ----------------------------------------------------------------------------
`default_nettype none
module rwd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rwd_pkg::cmd_t  cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output logic                kind,
  output logic signed [15:0]  smp,
  output logic                slot,
  output logic [3:0]          st,
  output logic [31:0]         rate,
  output logic [1:0]          chans,
  output logic                last
);
  localparam int DEPTH = 4;
  rwd_pkg::cmd_t q_r [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       smp_done_r;   // sample half of head word already delivered
  logic       head_v, pop_word, do_pop;

  assign full   = (cnt_r == 3'(DEPTH));
  assign head_v = (cnt_r != 3'd0);
  assign empty  = !head_v;
  // head word: sample first, then status
  always_comb begin
    kind  = 1'b0; smp = '0; slot = 1'b0; st = '0; last = 1'b0;
    rate  = q_r[rp_r].rate; chans = q_r[rp_r].chans;
    if (q_r[rp_r].has_smp && !smp_done_r) begin
      smp = q_r[rp_r].smp; slot = q_r[rp_r].slot;
    end else begin
      kind = 1'b1; st = q_r[rp_r].st; last = 1'b1;
    end
  end
  assign do_pop   = pop && head_v;
  assign pop_word = do_pop && (kind || !q_r[rp_r].has_st);

  // queue storage and pointers
  always_ff @(posedge clk) begin
    if (push && !full) q_r[wp_r] <= cmd;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; smp_done_r <= 1'b0;
    end else begin
      if (push && !full) wp_r <= wp_r + 2'd1;
      if (pop_word) begin rp_r <= rp_r + 2'd1; smp_done_r <= 1'b0; end
      else if (do_pop) smp_done_r <= 1'b1;
      cnt_r <= cnt_r + 3'(push && !full) - 3'(pop_word);
    end
  end

  `include "riff_wave_pcm_stream_decoder_top_defines.svh"
  `RWD_ASSERT_IMP(a_cnt, clk, rst_n, 1'b1, cnt_r <= 3'(DEPTH))
  `RWD_ASSERT_IMP(a_ok, clk, rst_n, head_v, q_r[rp_r].has_smp || q_r[rp_r].has_st)
  `RWD_ASSERT_IMP(a_last, clk, rst_n, head_v && last, kind)
endmodule
`default_nettype wire

@@ design/riff_wave_pcm_stream_decoder_top.sv @@
// A byte's result is written into the command queue as the byte is taken.
// Throughput: one byte per clock while the queue is not full; a byte giving a sample and a status needs two pops.
// The four-word command queue between parser and sequencer sets the stall slack.
// Synchronous active-low reset returns the parser to the RIFF header phase
// and empties the queue; the last byte of a file does the same for the parser.
// ----------------------------------------------------------------------------
// riff_wave_pcm_stream_decoder_top
// WAVE byte stream decoder giving PCM samples and an end-of-file status word.
// ----------------------------------------------------------------------------
`default_nettype none
module riff_wave_pcm_stream_decoder_top #(
  parameter int unsigned MAX_FILE_BYTES    = rwd_pkg::MAX_FILE_BYTES_D,
  parameter int unsigned MAX_DECODED_BYTES = rwd_pkg::MAX_DECODED_BYTES_D
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    in_file_byte,
  input  wire logic          in_final_byte,
  output logic               empty,
  input  wire logic          pop,
  output logic               out_result_kind,
  output logic signed [15:0] out_pcm_sample,
  output logic               out_channel_slot,
  output logic [3:0]         out_status_code,
  output logic [31:0]        out_rate_hz,
  output logic [1:0]         out_channel_total,
  output logic               out_is_last
);
  rwd_pkg::cmd_t cmd;
  logic          useful, take;
  assign take = push && !full;

  rwd_front #(.MAX_FILE_BYTES(MAX_FILE_BYTES), .MAX_DECODED_BYTES(MAX_DECODED_BYTES))
  u_front (
    .clk(clk), .rst_n(rst_n), .in_take(take), .in_byte(in_file_byte),
    .in_last(in_final_byte), .cmd(cmd), .cmd_useful(useful)
  );

  rwd_back u_back (
    .clk(clk), .rst_n(rst_n), .push(take && useful), .cmd(cmd), .full(full),
    .pop(pop), .empty(empty), .kind(out_result_kind), .smp(out_pcm_sample),
    .slot(out_channel_slot), .st(out_status_code), .rate(out_rate_hz),
    .chans(out_channel_total), .last(out_is_last)
  );
endmodule
`default_nettype wire
